@@ hw/rtl/rlwc_pkg.sv @@
// ============================================================================
// Run-length window clipper package
// Shared types and constants for the run-length window clipper.
// ============================================================================
`default_nettype none

package rlwc_pkg;

    // Width of every pixel count field on the ports.
    localparam int FIELD_BITS = 24;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_BEGIN = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_END   = 1'b1;

    // Window phase codes. The spare code behaves as done.
    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_COPY = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // One result beat.
    typedef struct packed {
        logic                  has_run;
        logic [FIELD_BITS-1:0] out_background;
        logic [FIELD_BITS-1:0] out_foreground;
        logic                  window_done;
        logic [FIELD_BITS-1:0] active_before;
        logic [FIELD_BITS-1:0] active_through_end;
    } rlwc_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/run_length_window_clipper_core.sv @@
// ============================================================================
// Run-length window clipper core
// Clips a stream of background/foreground run pairs to a pixel window.
// ============================================================================
`default_nettype none

// The core takes one run pair per clock cycle while in_stall is low and
// gives at most one result beat for it. An accepted beat passes the input
// register and then the result register, where its result is presented. The
// rate is set by the combinational step logic that sits between the input
// register and the result register: it trims the run against the remaining
// skip and copy lengths and updates the counters in the same cycle, so the
// next run can follow at once, also after a run that gives no result. The
// window is reloaded from window_begin and window_end on every beat
// that has starts_image set, so register writes take effect at the next image.
// The final result of a window has window_done set and carries the active
// pixel counts; later runs of the same image are absorbed silently. in_stall
// follows out_stall combinationally through the two register stages.

module run_length_window_clipper_core
    import rlwc_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_write_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [FIELD_BITS-1:0]     cfg_write_data,

    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [FIELD_BITS-1:0]     background_count,
    input  wire logic [FIELD_BITS-1:0]     foreground_count,
    input  wire logic                      starts_image,

    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           has_run,
    output logic [FIELD_BITS-1:0]          out_background,
    output logic [FIELD_BITS-1:0]          out_foreground,
    output logic                           window_done,
    output logic [FIELD_BITS-1:0]          active_before,
    output logic [FIELD_BITS-1:0]          active_through_end
);

    // Working width for comparisons: wide enough for any count or field
    // value, plus one bit so that a background plus a foreground never wraps.
    localparam int SUM_BITS = ((COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS) + 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [FIELD_BITS-1:0] window_begin_reg;
    logic [FIELD_BITS-1:0] window_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_begin_reg <= '0;
            window_end_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_BEGIN: window_begin_reg <= cfg_write_data;
                REG_WINDOW_END:   window_end_reg   <= cfg_write_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. A beat moves on from here whenever the result
    // register can take whatever it produces.
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [FIELD_BITS-1:0] in_bg_reg;
    logic [FIELD_BITS-1:0] in_fg_reg;
    logic                  in_start_reg;
    logic                  can_load;
    logic                  advance;
    logic                  in_take;

    assign advance       = in_valid_reg && can_load;
    assign in_stall      = in_valid_reg && !can_load;
    assign in_take       = in_valid && !in_stall;
    assign in_valid_next = in_take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_bg_reg    <= background_count;
            in_fg_reg    <= foreground_count;
            in_start_reg <= starts_image;
        end
    end

    // ------------------------------------------------------------------
    // Window state.
    // ------------------------------------------------------------------
    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    logic [COUNT_BITS-1:0] skip_left_reg;
    logic [COUNT_BITS-1:0] skip_left_next;
    logic [COUNT_BITS-1:0] copy_left_reg;
    logic [COUNT_BITS-1:0] copy_left_next;
    logic [COUNT_BITS-1:0] active_prefix_reg;
    logic [COUNT_BITS-1:0] active_prefix_next;
    logic [COUNT_BITS-1:0] active_inside_reg;
    logic [COUNT_BITS-1:0] active_inside_next;

    logic                  emit;
    rlwc_result_t          result;

    // ------------------------------------------------------------------
    // Step logic for the beat in the input register.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [1:0]            ph;
        logic [COUNT_BITS-1:0] skip;
        logic [COUNT_BITS-1:0] copy;
        logic [COUNT_BITS-1:0] prefix;
        logic [COUNT_BITS-1:0] copied;
        logic [FIELD_BITS-1:0] span;
        logic [SUM_BITS-1:0]   bg_w;
        logic [SUM_BITS-1:0]   fg_w;
        logic [SUM_BITS-1:0]   s_w;
        logic [SUM_BITS-1:0]   n_w;
        logic [SUM_BITS-1:0]   k_w;
        logic                  proceed;
        logic                  copy_go;
        logic                  run;
        logic                  done;
        logic [SUM_BITS-1:0]   res_bg;
        logic [SUM_BITS-1:0]   res_fg;

        // A beat that starts an image first reloads the window.
        span = window_end_reg - window_begin_reg;
        if (in_start_reg)
        begin
            ph     = PH_SKIP;
            skip   = COUNT_BITS'(window_begin_reg);
            copy   = (window_end_reg > window_begin_reg) ? COUNT_BITS'(span) : '0;
            prefix = '0;
            copied = '0;
        end
        else
        begin
            ph     = phase_reg;
            skip   = skip_left_reg;
            copy   = copy_left_reg;
            prefix = active_prefix_reg;
            copied = active_inside_reg;
        end

        bg_w    = SUM_BITS'(in_bg_reg);
        fg_w    = SUM_BITS'(in_fg_reg);
        s_w     = SUM_BITS'(skip);
        n_w     = '0;
        k_w     = '0;
        proceed = 1'b0;
        copy_go = 1'b0;
        emit    = 1'b0;
        run     = 1'b0;
        done    = 1'b0;
        res_bg  = '0;
        res_fg  = '0;

        phase_next         = ph;
        skip_left_next     = skip;
        copy_left_next     = copy;
        active_prefix_next = prefix;
        active_inside_next = copied;

        unique case (ph)
            PH_SKIP:
            begin
                proceed = 1'b1;
                if (skip != '0)
                begin
                    if (s_w < bg_w)
                    begin
                        // Window starts inside the background.
                        bg_w           = bg_w - s_w;
                        skip_left_next = '0;
                    end
                    else
                    begin
                        n_w  = s_w - bg_w;
                        bg_w = '0;
                        if (n_w < fg_w)
                        begin
                            // Window starts inside the foreground.
                            fg_w               = fg_w - n_w;
                            active_prefix_next = prefix + COUNT_BITS'(n_w);
                            skip_left_next     = '0;
                        end
                        else
                        begin
                            // The skip swallows the whole run.
                            active_prefix_next = prefix + COUNT_BITS'(fg_w);
                            skip_left_next     = COUNT_BITS'(n_w - fg_w);
                            proceed            = 1'b0;
                            if (skip_left_next == '0)
                            begin
                                if (copy == '0)
                                begin
                                    phase_next = PH_DONE;
                                    emit       = 1'b1;
                                    done       = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_COPY;
                                end
                            end
                        end
                    end
                end
                if (proceed)
                begin
                    if (copy == '0)
                    begin
                        phase_next = PH_DONE;
                        emit       = 1'b1;
                        done       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_COPY;
                        copy_go    = 1'b1;
                    end
                end
            end
            PH_COPY:
            begin
                copy_go = 1'b1;
            end
            default:
            begin
                // Window finished: runs are absorbed until the next image.
            end
        endcase

        if (copy_go)
        begin
            emit = 1'b1;
            run  = 1'b1;
            if (SUM_BITS'(copy) <= bg_w)
            begin
                // The window ends within the background.
                res_bg         = SUM_BITS'(copy);
                copy_left_next = '0;
                phase_next     = PH_DONE;
                done           = 1'b1;
            end
            else if (SUM_BITS'(copy) <= bg_w + fg_w)
            begin
                // The window ends within the foreground.
                k_w                = SUM_BITS'(copy) - bg_w;
                active_inside_next = copied + COUNT_BITS'(k_w);
                res_bg             = bg_w;
                res_fg             = k_w;
                copy_left_next     = '0;
                phase_next         = PH_DONE;
                done               = 1'b1;
            end
            else
            begin
                active_inside_next = copied + COUNT_BITS'(fg_w);
                copy_left_next     = COUNT_BITS'(SUM_BITS'(copy) - bg_w - fg_w);
                res_bg             = bg_w;
                res_fg             = fg_w;
            end
        end

        result.has_run        = run;
        result.out_background = FIELD_BITS'(res_bg);
        result.out_foreground = FIELD_BITS'(res_fg);
        result.window_done    = done;
        if (done)
        begin
            result.active_before      = FIELD_BITS'(active_prefix_next);
            result.active_through_end =
                FIELD_BITS'(COUNT_BITS'(active_prefix_next + active_inside_next));
        end
        else
        begin
            result.active_before      = '0;
            result.active_through_end = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SKIP;
            skip_left_reg     <= '0;
            copy_left_reg     <= '0;
            active_prefix_reg <= '0;
            active_inside_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            skip_left_reg     <= skip_left_next;
            copy_left_reg     <= copy_left_next;
            active_prefix_reg <= active_prefix_next;
            active_inside_reg <= active_inside_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic         load;
    rlwc_result_t out_data;

    assign load = advance && emit;

    rlwc_result_reg u_result_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign has_run            = out_data.has_run;
    assign out_background     = out_data.out_background;
    assign out_foreground     = out_data.out_foreground;
    assign window_done        = out_data.window_done;
    assign active_before      = out_data.active_before;
    assign active_through_end = out_data.active_through_end;

`ifndef SYNTHESIS
    // A final result always leaves the window in the done phase.
    a_done_sets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (load && result.window_done) |=> (phase_reg == PH_DONE))
        else $error("final result did not close the window");

    // A finished window gives nothing until a new image starts.
    a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_start_reg && (phase_reg != PH_SKIP) && (phase_reg != PH_COPY))
        |-> !load)
        else $error("result produced after the window was done");

    // A result without a run is only ever the final one.
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_run) |-> window_done)
        else $error("result without a run is not final");

    // Counts are zero on every result that is not final.
    a_counts_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !window_done) |-> ((active_before == '0) && (active_through_end == '0)))
        else $error("counts reported before the window was done");

    // The input side stalls only while it holds a beat.
    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with an empty input register");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rlwc_result_reg.sv @@
// ============================================================================
// Run-length window clipper result register
// Holds one result beat and offers it downstream under valid and stall.
// ============================================================================
`default_nettype none

module rlwc_result_reg
    import rlwc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire rlwc_result_t load_data,
    output logic              can_load,
    output logic              out_valid,
    input  wire logic         out_stall,
    output rlwc_result_t      out_data
);

    logic         valid_reg;
    logic         valid_next;
    rlwc_result_t data_reg;

    // The register may take a new beat when it is empty or its beat leaves now.
    assign can_load   = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ============================================================================
// Run-length window clipper testbench
// Feeds images as run-pair beats to the clipper core under random idling and
// back-pressure. A predictor in this file works out the expected result beats
// and checks them in order against what the core delivers.
// ============================================================================
`timescale 1ns / 100ps

module testbench
    import rlwc_pkg::*;
();

    localparam longint unsigned COUNT_MAX   = 64'hFF_FFFF;
    localparam int              CYCLE_LIMIT = 1_000_000;
    // The core presents a result once a beat has passed its input register and
    // its result register. A run that gives no result may still be in the
    // pipeline when the last result has arrived, so a drain wait follows before
    // a register write or the end.
    localparam int              DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [FIELD_BITS-1:0] bg;
        logic [FIELD_BITS-1:0] fg;
        logic                  first;
    } run_beat_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;

    logic                      cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_WINDOW_BEGIN;
    logic [FIELD_BITS-1:0]     cfg_write_data = '0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [FIELD_BITS-1:0]     background_count = '0;
    logic [FIELD_BITS-1:0]     foreground_count = '0;
    logic                      starts_image = 1'b0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      has_run;
    logic [FIELD_BITS-1:0]     out_background;
    logic [FIELD_BITS-1:0]     out_foreground;
    logic                      window_done;
    logic [FIELD_BITS-1:0]     active_before;
    logic [FIELD_BITS-1:0]     active_through_end;

    run_length_window_clipper_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_write_data     (cfg_write_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .background_count   (background_count),
        .foreground_count   (foreground_count),
        .starts_image       (starts_image),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .has_run            (has_run),
        .out_background     (out_background),
        .out_foreground     (out_foreground),
        .window_done        (window_done),
        .active_before      (active_before),
        .active_through_end (active_through_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: the register copies and the window being worked on.
    // ------------------------------------------------------------------------
    longint unsigned win_begin_cfg = 0;
    longint unsigned win_end_cfg   = 0;
    logic [1:0]      win_phase     = PH_SKIP;
    longint unsigned pixels_to_skip = 0;
    longint unsigned pixels_to_copy = 0;
    longint unsigned active_skipped = 0;
    longint unsigned active_copied  = 0;

    run_beat_t    runs_to_send[$];
    rlwc_result_t clip_expected[$];

    int          runs_accepted = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit          sender_calm = 1'b0;
    bit          receiver_calm = 1'b0;
    logic        receiver_hold = 1'b0;

    // A new image starts with the skip at the window start and the copy
    // length at the window length, or zero when the end is not above it.
    function automatic void reload_window();
        win_phase      = PH_SKIP;
        pixels_to_skip = win_begin_cfg;
        pixels_to_copy = (win_end_cfg > win_begin_cfg) ? win_end_cfg - win_begin_cfg : 0;
        active_skipped = 0;
        active_copied  = 0;
    endfunction

    // The run fields are zero without a run, and the counts are zero until
    // the window is done.
    function automatic rlwc_result_t make_result(bit run, longint unsigned bg,
                                                 longint unsigned fg, bit done);
        rlwc_result_t    r;
        longint unsigned through;
        through = (active_skipped + active_copied) & COUNT_MAX;
        r.has_run            = run;
        r.out_background     = run ? bg[FIELD_BITS-1:0] : '0;
        r.out_foreground     = run ? fg[FIELD_BITS-1:0] : '0;
        r.window_done        = done;
        r.active_before      = done ? active_skipped[FIELD_BITS-1:0] : '0;
        r.active_through_end = done ? through[FIELD_BITS-1:0] : '0;
        return r;
    endfunction

    // Clips one run against the window. Returns 1 when the run gives a
    // result beat, which is then left in res.
    function automatic bit clip_run(input logic [FIELD_BITS-1:0] bg_in,
                                    input logic [FIELD_BITS-1:0] fg_in,
                                    input logic first, output rlwc_result_t res);
        longint unsigned bg;
        longint unsigned fg;
        longint unsigned n;
        bg  = bg_in;
        fg  = fg_in;
        res = '0;
        if (first)
            reload_window();

        if (win_phase == PH_SKIP)
        begin
            if (pixels_to_skip > 0)
            begin
                n = pixels_to_skip;
                if (n < bg)
                begin
                    bg -= n;
                    pixels_to_skip = 0;
                end
                else
                begin
                    n -= bg;
                    bg = 0;
                    if (n < fg)
                    begin
                        fg -= n;
                        active_skipped = (active_skipped + n) & COUNT_MAX;
                        pixels_to_skip = 0;
                    end
                    else
                    begin
                        // The skip swallows the whole run; copying, if any,
                        // begins with the next beat.
                        active_skipped = (active_skipped + fg) & COUNT_MAX;
                        pixels_to_skip = (n - fg) & COUNT_MAX;
                        if (pixels_to_skip != 0)
                            return 1'b0;
                        if (pixels_to_copy == 0)
                        begin
                            win_phase = PH_DONE;
                            res = make_result(1'b0, 0, 0, 1'b1);
                            return 1'b1;
                        end
                        win_phase = PH_COPY;
                        return 1'b0;
                    end
                end
            end
            if (pixels_to_copy == 0)
            begin
                win_phase = PH_DONE;
                res = make_result(1'b0, 0, 0, 1'b1);
                return 1'b1;
            end
            win_phase = PH_COPY;
        end

        if (win_phase != PH_COPY)
            return 1'b0;

        n = pixels_to_copy;
        if (n <= bg)
        begin
            // The window ends within the background, or on its last pixel.
            pixels_to_copy = 0;
            win_phase = PH_DONE;
            res = make_result(1'b1, n, 0, 1'b1);
            return 1'b1;
        end
        if (n <= bg + fg)
        begin
            active_copied  = (active_copied + n - bg) & COUNT_MAX;
            pixels_to_copy = 0;
            win_phase = PH_DONE;
            res = make_result(1'b1, bg, n - bg, 1'b1);
            return 1'b1;
        end
        active_copied  = (active_copied + fg) & COUNT_MAX;
        pixels_to_copy = (n - bg - fg) & COUNT_MAX;
        res = make_result(1'b1, bg, fg, 1'b0);
        return 1'b1;
    endfunction

    // Idle lengths: mostly none, often short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        if (r < 99)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Run lengths mostly near the window's scale so that images reach the
    // copy phase and the cut, with zeros, full-scale values and random bits
    // mixed in.
    function automatic logic [FIELD_BITS-1:0] pick_count(longint unsigned scale);
        longint unsigned v;
        int unsigned     r;
        r = $urandom_range(0, 99);
        if (r < 8)
            v = 0;
        else if (r < 80)
            v = $urandom_range(0, int'(scale));
        else if (r < 94)
            v = $urandom_range(0, int'(scale * 3));
        else if (r < 97)
            v = COUNT_MAX;
        else
            v = $urandom & COUNT_MAX;
        if (v > COUNT_MAX)
            v = COUNT_MAX;
        return v[FIELD_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers the queued runs, with random gaps between beats. A beat
    // is predicted at the edge where the core takes it. in_valid gets exactly
    // one assignment per edge so that back-to-back beats keep it high.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rlwc_result_t res;
        run_beat_t    beat;
        logic         next_valid;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                if (clip_run(background_count, foreground_count, starts_image, res))
                    clip_expected = {clip_expected, res};
                runs_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (runs_to_send.size() != 0)
                begin
                    beat = runs_to_send.pop_front();
                    background_count <= beat.bg;
                    foreground_count <= beat.fg;
                    starts_image     <= beat.first;
                    next_valid = 1'b1;
                    send_gap = sender_calm ? 0 : pick_gap();
                end
            end
            in_valid <= next_valid;
        end
    end

    function automatic void check_field(string name, logic [FIELD_BITS-1:0] want,
                                        logic [FIELD_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: checks every result beat against the oldest expectation and
    // drives out_stall, either at random or held high during the hold-off.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rlwc_result_t seen;
        rlwc_result_t want;
        int unsigned  n;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = {has_run, out_background, out_foreground, window_done,
                        active_before, active_through_end};
                if (clip_expected.size() == 0)
                begin
                    $error("result beat with no expectation waiting: has_run %0d done %0d",
                           seen.has_run, seen.window_done);
                    mismatches++;
                end
                else
                begin
                    want = clip_expected.pop_front();
                    check_field("has_run", FIELD_BITS'(want.has_run),
                                FIELD_BITS'(seen.has_run));
                    check_field("out_background", want.out_background, seen.out_background);
                    check_field("out_foreground", want.out_foreground, seen.out_foreground);
                    check_field("window_done", FIELD_BITS'(want.window_done),
                                FIELD_BITS'(seen.window_done));
                    check_field("active_before", want.active_before, seen.active_before);
                    check_field("active_through_end", want.active_through_end,
                                seen.active_through_end);
                end
            end

            if (receiver_hold)
                out_stall <= 1'b1;
            else if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                n = receiver_calm ? 0 : pick_gap();
                out_stall <= (n != 0);
                stall_left = (n != 0) ? n - 1 : 0;
            end
        end
    end

    // Long hold-off while the sender keeps offering: the core must fill and
    // push back on its input.
    initial
    begin
        wait (runs_accepted >= 300);
        @(posedge clk);
        receiver_hold <= 1'b1;
        repeat (400) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_run(input longint unsigned bg, input longint unsigned fg,
                             input bit first);
        run_beat_t beat;
        beat.bg    = bg[FIELD_BITS-1:0];
        beat.fg    = fg[FIELD_BITS-1:0];
        beat.first = first;
        runs_to_send = {runs_to_send, beat};
    endtask

    // Registers are only written with the core idle, so the predictor copy
    // can follow at once; the core picks the value up at the next image.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input longint unsigned value);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_index      <= idx;
        cfg_write_data <= value[FIELD_BITS-1:0];
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        if (idx == REG_WINDOW_BEGIN)
            win_begin_cfg = value & COUNT_MAX;
        else
            win_end_cfg = value & COUNT_MAX;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (runs_to_send.size() != 0 || in_valid || clip_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Queues whole images for the current window: each one opens with
    // starts_image and runs on until it has covered the window, though now
    // and then it stops short. A stray starts_image and now and then one
    // extra run after the window is done are mixed in as noise.
    task automatic queue_images(input longint unsigned wb, input longint unsigned we,
                                input int target);
        longint unsigned span;
        longint unsigned scale;
        longint unsigned covered;
        run_beat_t       beat;
        int              useful;
        int              runs;
        useful = 0;
        span   = (we > wb) ? we : wb + 64;
        scale  = span / 5 + 1;
        while (useful < target)
        begin
            covered = 0;
            runs    = 0;
            do
            begin
                beat.first = (runs == 0) ? 1'b1 : ($urandom_range(0, 49) == 0);
                beat.bg    = pick_count(scale);
                beat.fg    = pick_count(scale);
                covered   += beat.bg + beat.fg;
                runs_to_send = {runs_to_send, beat};
                runs++;
                useful++;
            end
            while (covered < span && runs < 48 && $urandom_range(0, 29) != 0);
            if ($urandom_range(0, 3) == 0)
                queue_run(pick_count(scale), pick_count(scale), 1'b0);
        end
    endtask

    initial
    begin
        longint unsigned wb;
        longint unsigned we;

        reload_window();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Registers still at reset: an empty window with no skip, so the
        // first beat, even without starts_image, gives the final result.
        sender_calm = 1'b1;
        queue_run(7, 9, 1'b0);
        queue_run(5, 5, 1'b1);
        queue_run(3, 3, 1'b0);
        wait_drained();

        // Window 10 to 20: a skip that ends exactly at a run end, an empty
        // run inside the window, a cut on the background boundary, runs after
        // done, a trimmed first run, an image that ends before the window and
        // a skip that ends inside a foreground.
        sender_calm = 1'b0;
        write_reg(REG_WINDOW_BEGIN, 10);
        write_reg(REG_WINDOW_END, 20);
        queue_run(4, 3, 1'b1);
        queue_run(2, 1, 1'b0);
        queue_run(0, 0, 1'b0);
        queue_run(3, 4, 1'b0);
        queue_run(3, 5, 1'b0);
        queue_run(1, 1, 1'b0);
        queue_run(15, 2, 1'b1);
        queue_run(1, 100, 1'b0);
        queue_run(2, 3, 1'b1);
        queue_run(0, 30, 1'b1);
        wait_drained();

        // End below begin, at the top of the range.
        write_reg(REG_WINDOW_BEGIN, COUNT_MAX);
        write_reg(REG_WINDOW_END, 0);
        queue_run(COUNT_MAX, COUNT_MAX, 1'b1);
        wait_drained();

        // Empty window whose skip ends exactly at a run end.
        write_reg(REG_WINDOW_BEGIN, 5);
        write_reg(REG_WINDOW_END, 5);
        queue_run(2, 3, 1'b1);
        wait_drained();

        // Widest window, with full-scale runs.
        write_reg(REG_WINDOW_BEGIN, 0);
        write_reg(REG_WINDOW_END, COUNT_MAX);
        queue_run(COUNT_MAX, COUNT_MAX, 1'b1);
        queue_run(1, COUNT_MAX, 1'b1);
        queue_run(0, 0, 1'b1);
        queue_run(0, COUNT_MAX, 1'b0);
        wait_drained();

        // Random part: one window setting per phase, extremes among them.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    wb = $urandom_range(0, 40);
                    we = wb + $urandom_range(1, 200);
                end
                1:
                begin
                    wb = 0;
                    we = COUNT_MAX;
                end
                2:
                begin
                    wb = COUNT_MAX;
                    we = COUNT_MAX;
                end
                3:
                begin
                    wb = $urandom_range(100, 5000);
                    we = $urandom_range(0, int'(wb) - 1);
                end
                4:
                begin
                    wb = $urandom_range(1, 300);
                    we = wb;
                end
                5:
                begin
                    wb = $urandom & COUNT_MAX;
                    we = $urandom & COUNT_MAX;
                end
                6:
                begin
                    wb = $urandom_range(0, 1000);
                    we = wb + $urandom_range(1, 3000);
                end
                default:
                begin
                    wb = COUNT_MAX - $urandom_range(0, 300);
                    we = COUNT_MAX;
                end
            endcase
            sender_calm   = (p % 4 == 1) || ($urandom_range(0, 3) == 0);
            receiver_calm = (p % 4 == 2) || ($urandom_range(0, 3) == 0);
            write_reg(REG_WINDOW_BEGIN, wb);
            write_reg(REG_WINDOW_END, we);
            queue_images(wb, we, 190);
            wait_drained();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
